// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the paletted texel expander.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PTE_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("pte assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PTE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("pte assertion failed");

`endif

// ----- hw/rtl/pte_pkg.sv -----
// Package of the paletted texel expander: types, codes, defaults and colour conversion.
`default_nettype none

package pte_pkg;

    localparam int PTE_PALETTE_DEPTH = 256;
    localparam int PTE_STAGE_SIZE    = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int COLOUR_W   = 15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd4;

    // reset values of the configuration registers
    localparam logic                  RST_WIDE_MODE   = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RST_RECT_WIDTH  = 9'd256;
    localparam logic [CFG_DATA_W-1:0] RST_RECT_HEIGHT = 9'd256;
    localparam logic [CFG_DATA_W-1:0] RST_ORIGIN      = 9'd0;

    // item kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOW,
        ST_HIGH
    } pte_state_t;

    // Swap red and blue, drop the flag bit; an unflagged colour is black,
    // a flagged colour that comes out black becomes 1.
    function automatic logic [COLOUR_W-1:0] convert_colour(input logic [15:0] raw);
        logic [COLOUR_W-1:0] c;
        c = {raw[4:0], raw[9:5], raw[14:10]};
        if (!raw[15])
            c = '0;
        else if (c == '0)
            c = 15'd1;
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/paletted_texel_expander.sv -----
// Top level of the paletted texel expander: palette RAM, texel sequencer and counters.
`default_nettype none
`include "assert_macros.svh"

// Paletted texel expander.
// An item is taken at a rising edge with start high and busy low. A palette
// load (mode 0) converts data_value and writes it to the palette RAM at
// entry_index; it gives no texel. A pixel beat (mode 1) carries one byte in
// data_value[7:0]. In 8 bpp mode it gives one texel, in 4 bpp mode two (low
// nibble first). Each texel appears on texel, column, row and last for
// exactly one cycle while result_valid is high; the receiver cannot stall,
// so take every texel in the cycle it is shown. The first texel of a pixel
// beat comes in the cycle after the beat is taken, as the palette RAM has a
// registered read port. 8 bpp bytes may stream back to back; a 4 bpp byte
// does one RAM read per nibble, and busy is high while its first texel is
// shown, so a new byte is taken no earlier than its second texel.
// Pixel beats give no texels when the rectangle check on origin and size
// fails or the rectangle is empty; an odd width in 4 bpp drops the last
// column. Configuration is written through cfg_valid / cfg_ready while the
// block is idle; every write to a listed register restarts the rectangle at
// column 0, row 0. Palette entries must be loaded before a pixel reads them;
// the RAM needs no clearing pass after reset.
module paletted_texel_expander #(
    parameter int PALETTE_DEPTH = pte_pkg::PTE_PALETTE_DEPTH,
    parameter int STAGE_SIZE    = pte_pkg::PTE_STAGE_SIZE
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // item channel
    input  wire logic                            start,
    output      logic                            busy,
    input  wire logic                            mode,
    input  wire logic [7:0]                      entry_index,
    input  wire logic [15:0]                     data_value,
    // result channel
    output      logic                            result_valid,
    output      logic [pte_pkg::COLOUR_W-1:0]    texel,
    output      logic [7:0]                      column,
    output      logic [7:0]                      row,
    output      logic                            last,
    // configuration channel
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [pte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pte_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pte_pkg::*;

    localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
    localparam int STAGE_W = $clog2(STAGE_SIZE + 1);
    localparam int CMP_W   = (STAGE_W > CFG_DATA_W + 1) ? STAGE_W : CFG_DATA_W + 1;

    localparam logic [8:0]       PAL_LIMIT   = 9'(PALETTE_DEPTH);
    localparam logic [CMP_W-1:0] STAGE_LIMIT = CMP_W'(STAGE_SIZE);

    // configuration registers
    logic                  wide_mode_reg;
    logic [CFG_DATA_W-1:0] rect_width_reg;
    logic [CFG_DATA_W-1:0] rect_height_reg;
    logic [CFG_DATA_W-1:0] origin_x_reg;
    logic [CFG_DATA_W-1:0] origin_y_reg;

    // rectangle position of the next texel
    logic [CFG_DATA_W-1:0] col_reg, col_next;
    logic [CFG_DATA_W-1:0] row_reg, row_next;

    // sequencer
    pte_state_t state_reg, state_next;
    logic       four_bit_reg;
    logic [3:0] hi_nib_reg;
    logic       zero_reg;

    // palette RAM
    logic [COLOUR_W-1:0] palette_mem [PALETTE_DEPTH];
    logic [COLOUR_W-1:0] rd_data_reg;
    logic                rd_en;
    logic [PAL_AW-1:0]   rd_addr;
    logic                wr_en;

    logic                  accept;
    logic                  pix_go;
    logic                  rect_ok;
    logic                  cfg_go;
    logic                  cfg_restart;
    logic [CFG_DATA_W-1:0] eff_width;
    logic                  wrap_col;
    logic                  wrap_row;

    // effective width: round down to even columns in 4 bpp
    assign eff_width = wide_mode_reg ? rect_width_reg : {rect_width_reg[8:1], 1'b0};

    // rectangle check on origin and size, and no empty rectangle
    assign rect_ok = (CMP_W'(origin_x_reg) < STAGE_LIMIT)
                  && (CMP_W'(origin_y_reg) < STAGE_LIMIT)
                  && (CMP_W'(rect_width_reg) <= STAGE_LIMIT)
                  && (CMP_W'(rect_height_reg) <= STAGE_LIMIT)
                  && (CMP_W'(origin_x_reg) + CMP_W'(rect_width_reg) <= STAGE_LIMIT)
                  && (CMP_W'(origin_y_reg) + CMP_W'(rect_height_reg) <= STAGE_LIMIT)
                  && (eff_width != '0)
                  && (rect_height_reg != '0);

    assign cfg_ready   = (state_reg == ST_IDLE);
    assign cfg_go      = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_go && (cfg_index <= CFG_ORIGIN_Y);

    // a 4 bpp byte holds the read port for its second nibble
    assign busy   = (state_reg == ST_LOW) && four_bit_reg;
    assign accept = start && !busy;
    assign pix_go = accept && (mode == MODE_PIXEL) && rect_ok;
    assign wr_en  = accept && (mode == MODE_LOAD) && ({1'b0, entry_index} < PAL_LIMIT);

    // advance column and row on each texel shown
    assign wrap_col = ({1'b0, col_reg} + 10'd1) >= {1'b0, eff_width};
    assign wrap_row = ({1'b0, row_reg} + 10'd1) >= {1'b0, rect_height_reg};

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = PAL_AW'(data_value[7:0]);
        col_next   = col_reg;
        row_next   = row_reg;

        if (state_reg != ST_IDLE)
        begin
            if (wrap_col)
            begin
                col_next = '0;
                row_next = wrap_row ? '0 : row_reg + 9'd1;
            end
            else
            begin
                col_next = col_reg + 9'd1;
            end
        end

        // a write to a listed register restarts the rectangle
        if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_go)
                    state_next = ST_LOW;
            end
            ST_LOW:
            begin
                if (four_bit_reg)
                    state_next = ST_HIGH;
                else if (pix_go)
                    state_next = ST_LOW;
                else
                    state_next = ST_IDLE;
            end
            ST_HIGH:
            begin
                state_next = pix_go ? ST_LOW : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        priority if (pix_go)
        begin
            rd_en   = 1'b1;
            rd_addr = wide_mode_reg ? PAL_AW'(data_value[7:0]) : PAL_AW'(data_value[3:0]);
        end
        else if (busy)
        begin
            rd_en   = 1'b1;
            rd_addr = PAL_AW'(hi_nib_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            wide_mode_reg   <= RST_WIDE_MODE;
            rect_width_reg  <= RST_RECT_WIDTH;
            rect_height_reg <= RST_RECT_HEIGHT;
            origin_x_reg    <= RST_ORIGIN;
            origin_y_reg    <= RST_ORIGIN;
            col_reg         <= '0;
            row_reg         <= '0;
            four_bit_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (pix_go)
                four_bit_reg <= !wide_mode_reg;
            else if (state_reg == ST_LOW)
                four_bit_reg <= 1'b0;

            if (cfg_go)
            begin
                case (cfg_index)
                    CFG_WIDE_MODE:
                    begin
                        wide_mode_reg <= cfg_data[0];
                    end
                    CFG_RECT_WIDTH:
                    begin
                        rect_width_reg <= cfg_data;
                    end
                    CFG_RECT_HEIGHT:
                    begin
                        rect_height_reg <= cfg_data;
                    end
                    CFG_ORIGIN_X:
                    begin
                        origin_x_reg <= cfg_data;
                    end
                    CFG_ORIGIN_Y:
                    begin
                        origin_y_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // item payload held for the texel cycles
    always_ff @(posedge clk)
    begin
        if (pix_go)
        begin
            hi_nib_reg <= data_value[7:4];
            zero_reg   <= wide_mode_reg && ({1'b0, data_value[7:0]} >= PAL_LIMIT);
        end
    end

    // palette RAM: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            palette_mem[PAL_AW'(entry_index)] <= convert_colour(data_value);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= palette_mem[rd_addr];
    end

    assign result_valid = (state_reg != ST_IDLE);
    assign texel        = zero_reg ? '0 : rd_data_reg;
    assign column       = col_reg[7:0];
    assign row          = row_reg[7:0];
    assign last         = result_valid && wrap_col && wrap_row;

    `PTE_ASSERT_NOW(a_col_in_rect, clk, rst_n, result_valid, col_reg < eff_width)
    `PTE_ASSERT_NEXT(a_pixel_shows, clk, rst_n, pix_go, result_valid)
    `PTE_ASSERT_NOW(a_high_after_low, clk, rst_n, state_reg == ST_HIGH, $past(state_reg) == ST_LOW)
    `PTE_ASSERT_NEXT(a_cfg_restart, clk, rst_n, cfg_restart, (col_reg == '0) && (row_reg == '0))
    `PTE_ASSERT_NEXT(a_last_wraps, clk, rst_n, last, (col_reg == '0) && (row_reg == '0))

endmodule

`default_nettype wire
